// ----- design/prt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_pkg
// shared types and codes of the primitive root test block
// ----------------------------------------------------------------------------
package prt_pkg;

  // divider operand selection
  localparam logic [1:0] DIV_FACT   = 2'd0;  // rest / trial divisor
  localparam logic [1:0] DIV_REDUCE = 2'd1;  // candidate mod p
  localparam logic [1:0] DIV_EXP    = 2'd2;  // (p-1) / factor

  // multiplier operand selection
  localparam logic MUL_ACC = 1'b0;  // acc * sq
  localparam logic MUL_SQ  = 1'b1;  // sq * sq

  // controller to datapath commands
  typedef struct packed {
    logic       load_cand;
    logic       fact_init;
    logic       dd_calc;
    logic       div_start;
    logic [1:0] div_sel;
    logic       rest_from_quot;
    logic       append_d;
    logic       append_rest;
    logic       d_inc;
    logic       g_from_rem;
    logic       idx_clr;
    logic       idx_inc;
    logic       tab_read;
    logic       exp_load;
    logic       mul_start;
    logic       mul_sel;
    logic       acc_from_mul;
    logic       sq_from_mul;
    logic       out_load;
    logic       out_bit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic p_lt2;
    logic div_done;
    logic mul_done;
    logic rem_zero;
    logic fact_more;
    logic rest_gt1;
    logic idx_end;
    logic e_zero;
    logic e_lsb;
    logic acc_one;
  } status_t;

endpackage

// ----- design/prt_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module prt_div #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic [W:0]    rem_r;
  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic [W:0]    shifted;
  logic          take;

  assign shifted = {rem_r[W-1:0], quot[W-1]};
  assign take    = shifted >= {1'b0, dsr};
  assign rem     = rem_r[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quot  <= dividend;
      dsr   <= divisor;
    end else if (busy) begin
      rem_r <= take ? (shifted - {1'b0, dsr}) : shifted;
      quot  <= {quot[W-2:0], take};
    end
  end

endmodule

// ----- design/prt_modmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_modmul
// interleaved shift-add modular multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module prt_modmul #(
  parameter int W = 31
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         busy,
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  a_r;
  logic [W-1:0]  b_r;
  logic [W-1:0]  m_r;
  logic [CW-1:0] cnt;
  logic [W+1:0]  t0;
  logic [W+1:0]  t1;
  logic [W+1:0]  t2;
  logic [W+1:0]  mx;

  // acc < m and a < m, so 2*acc + a < 3m: two subtractions at most
  assign mx = {2'b00, m_r};
  assign t0 = {1'b0, prod, 1'b0} + (b_r[W-1] ? {2'b00, a_r} : '0);
  assign t1 = (t0 >= mx) ? (t0 - mx) : t0;
  assign t2 = (t1 >= mx) ? (t1 - mx) : t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_r  <= b;
      m_r  <= m;
      prod <= '0;
    end else if (busy) begin
      prod <= t2[W-1:0];
      b_r  <= {b_r[W-2:0], 1'b0};
    end
  end

endmodule

// ----- design/prt_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_datapath
// modulus, factor table, exponent registers, divider and multiplier
// ----------------------------------------------------------------------------
module prt_datapath #(
  parameter int W    = 31,
  parameter int MAXF = 16,
  parameter int TL   = 65536
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [W-1:0]     cfg_value,
  input  logic [W-1:0]     candidate,
  input  prt_pkg::cmd_t    cmd,
  output prt_pkg::status_t status
);

  import prt_pkg::*;

  localparam int DW  = $clog2(TL + 1);
  localparam int SW  = (2 * DW > W) ? 2 * DW : W;
  localparam int IW  = $clog2(MAXF);
  localparam int CNW = $clog2(MAXF + 1);
  localparam logic [DW-1:0] LIMIT = DW'(TL);

  logic [W-1:0]    p;
  logic [W-1:0]    g_raw;
  logic [W-1:0]    g;
  logic [W-1:0]    rest;
  logic [DW-1:0]   d;
  logic [2*DW-1:0] dd;
  logic [CNW-1:0]  count;
  logic [CNW-1:0]  idx;
  logic [W-1:0]    factor_table [MAXF];
  logic [W-1:0]    tab_rd;
  logic [W-1:0]    e;
  logic [W-1:0]    acc;
  logic [W-1:0]    sq;
  logic [W-1:0]    pm1;
  logic [W+DW-1:0] dext;
  logic [W-1:0]    append_val;

  logic [W-1:0] div_a;
  logic [W-1:0] div_b;
  logic         div_busy;
  logic         div_done;
  logic [W-1:0] quot;
  logic [W-1:0] rem;

  logic [W-1:0] mul_b;
  logic         mul_busy;
  logic         mul_done;
  logic [W-1:0] prod;

  assign pm1        = p - W'(1);
  assign dext       = {{W{1'b0}}, d};
  assign append_val = cmd.append_d ? dext[W-1:0] : rest;

  always_comb begin
    case (cmd.div_sel)
      DIV_FACT: begin
        div_a = rest;
        div_b = dext[W-1:0];
      end
      DIV_REDUCE: begin
        div_a = g_raw;
        div_b = p;
      end
      default: begin
        div_a = pm1;
        div_b = tab_rd;
      end
    endcase
  end

  assign mul_b = (cmd.mul_sel == MUL_ACC) ? acc : sq;

  prt_div #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  prt_modmul #(.W(W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (sq),
    .b     (mul_b),
    .m     (p),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (prod)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      p     <= W'(2);
      count <= '0;
      idx   <= '0;
    end else begin
      if (cfg_write) begin
        p <= cfg_value;
      end
      if (cmd.fact_init) begin
        count <= '0;
      end else if ((cmd.append_d || cmd.append_rest) && (count < CNW'(MAXF))) begin
        count <= count + 1'b1;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // factor table
  always_ff @(posedge clk) begin
    if ((cmd.append_d || cmd.append_rest) && (count < CNW'(MAXF))) begin
      factor_table[count[IW-1:0]] <= append_val;
    end
    if (cmd.tab_read) begin
      tab_rd <= factor_table[idx[IW-1:0]];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_cand) begin
      g_raw <= candidate;
    end
    if (cmd.fact_init) begin
      rest <= pm1;
      d    <= DW'(2);
    end else begin
      if (cmd.rest_from_quot) begin
        rest <= quot;
      end
      if (cmd.d_inc) begin
        d <= d + 1'b1;
      end
    end
    if (cmd.dd_calc) begin
      dd <= d * d;
    end
    if (cmd.g_from_rem) begin
      g <= rem;
    end
    if (cmd.exp_load) begin
      e   <= quot;
      acc <= W'(1);
      sq  <= g;
    end else begin
      if (cmd.acc_from_mul) begin
        acc <= prod;
      end
      if (cmd.sq_from_mul) begin
        sq <= prod;
        e  <= {1'b0, e[W-1:1]};
      end
    end
  end

  always_comb begin
    status.p_lt2     = p < W'(2);
    status.div_done  = div_done;
    status.mul_done  = mul_done;
    status.rem_zero  = rem == '0;
    status.fact_more = (d < LIMIT) && (SW'(dd) <= SW'(rest));
    status.rest_gt1  = rest > W'(1);
    status.idx_end   = idx == count;
    status.e_zero    = e == '0;
    status.e_lsb     = e[0];
    status.acc_one   = acc == W'(1);
  end

`ifndef SYNTH
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");
  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !mul_busy)
    else $error("multiplier started while busy");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CNW'(MAXF))
    else $error("factor count past table depth");
  a_read_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.tab_read |-> (idx < count))
    else $error("factor table read beyond fill");
`endif

endmodule

// ----- design/prt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prt_ctrl
// sequencer for factorisation, reduction and exponent checks
// ----------------------------------------------------------------------------
module prt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             in_accept,
  input  logic             out_free,
  input  prt_pkg::status_t status,
  output logic             idle,
  output prt_pkg::cmd_t    cmd
);

  import prt_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_FINIT  = 5'd1;
  localparam logic [4:0] S_FSQ    = 5'd2;
  localparam logic [4:0] S_FCMP   = 5'd3;
  localparam logic [4:0] S_FSTART = 5'd4;
  localparam logic [4:0] S_FDIV   = 5'd5;
  localparam logic [4:0] S_FTAIL  = 5'd6;
  localparam logic [4:0] S_RSTART = 5'd7;
  localparam logic [4:0] S_RWAIT  = 5'd8;
  localparam logic [4:0] S_QNEXT  = 5'd9;
  localparam logic [4:0] S_QREAD  = 5'd10;
  localparam logic [4:0] S_EWAIT  = 5'd11;
  localparam logic [4:0] S_POW    = 5'd12;
  localparam logic [4:0] S_MACC   = 5'd13;
  localparam logic [4:0] S_MSQ    = 5'd14;
  localparam logic [4:0] S_DONE   = 5'd15;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       ready;
  logic       ready_next;
  logic       found;
  logic       found_next;
  logic       res;
  logic       res_next;

  assign idle = state == S_IDLE;

  always_comb begin
    state_next = state;
    ready_next = ready;
    found_next = found;
    res_next   = res;
    cmd        = '0;
    cmd.out_bit = res;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          cmd.load_cand = 1'b1;
          if (status.p_lt2) begin
            res_next   = 1'b0;
            state_next = S_DONE;
          end else if (!ready) begin
            state_next = S_FINIT;
          end else begin
            state_next = S_RSTART;
          end
        end
      end
      S_FINIT: begin
        cmd.fact_init = 1'b1;
        found_next    = 1'b0;
        state_next    = S_FSQ;
      end
      S_FSQ: begin
        cmd.dd_calc = 1'b1;
        state_next  = S_FCMP;
      end
      S_FCMP: begin
        state_next = status.fact_more ? S_FSTART : S_FTAIL;
      end
      S_FSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_FACT;
        state_next    = S_FDIV;
      end
      S_FDIV: begin
        if (status.div_done) begin
          if (status.rem_zero) begin
            cmd.rest_from_quot = 1'b1;
            cmd.append_d       = !found;
            found_next         = 1'b1;
            state_next         = S_FSTART;
          end else begin
            cmd.d_inc  = 1'b1;
            found_next = 1'b0;
            state_next = S_FSQ;
          end
        end
      end
      S_FTAIL: begin
        cmd.append_rest = status.rest_gt1;
        ready_next      = 1'b1;
        state_next      = S_RSTART;
      end
      S_RSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_REDUCE;
        state_next    = S_RWAIT;
      end
      S_RWAIT: begin
        if (status.div_done) begin
          cmd.g_from_rem = 1'b1;
          cmd.idx_clr    = 1'b1;
          if (status.rem_zero) begin
            res_next   = 1'b0;
            state_next = S_DONE;
          end else begin
            state_next = S_QNEXT;
          end
        end
      end
      S_QNEXT: begin
        if (status.idx_end) begin
          res_next   = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.tab_read = 1'b1;
          state_next   = S_QREAD;
        end
      end
      S_QREAD: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_EXP;
        state_next    = S_EWAIT;
      end
      S_EWAIT: begin
        cmd.div_sel = DIV_EXP;
        if (status.div_done) begin
          cmd.exp_load = 1'b1;
          state_next   = S_POW;
        end
      end
      S_POW: begin
        if (status.e_zero) begin
          if (status.acc_one) begin
            res_next   = 1'b0;
            state_next = S_DONE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_QNEXT;
          end
        end else if (status.e_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_ACC;
          state_next    = S_MACC;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MUL_SQ;
          state_next    = S_MSQ;
        end
      end
      S_MACC: begin
        if (status.mul_done) begin
          cmd.acc_from_mul = 1'b1;
          cmd.mul_start    = 1'b1;
          cmd.mul_sel      = MUL_SQ;
          state_next       = S_MSQ;
        end
      end
      S_MSQ: begin
        if (status.mul_done) begin
          cmd.sq_from_mul = 1'b1;
          state_next      = S_POW;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cfg_write) begin
      ready_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready <= 1'b0;
      found <= 1'b0;
      res   <= 1'b0;
    end else begin
      state <= state_next;
      ready <= ready_next;
      found <= found_next;
      res   <= res_next;
    end
  end

`ifndef SYNTH
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> (state == S_IDLE))
    else $error("word accepted outside idle");
  a_cfg_drop: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> !ready)
    else $error("factor cache still marked ready after config write");
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (state == S_DONE) && out_free)
    else $error("result loaded outside done");
`endif

endmodule

// ----- design/primitive_root_test_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// primitive_root_test_top
// primitive root test of stream candidates modulo a configured prime
// ----------------------------------------------------------------------------
// Each candidate word g is tested as a primitive root modulo the prime P held
// in the configuration register (reset value 2). The block takes one word at
// a time. On the first candidate after reset or after a config write it
// factorises P-1 by trial division in the shared restoring divider, for
// divisors below TRIAL_LIMIT whose square does not exceed the remaining
// cofactor, dividing repeatedly by each factor found. After that every
// candidate is reduced mod P in the divider, and for each cached factor the
// exponent (P-1)/factor is formed in the divider and g is raised to it in the
// bit-serial modular multiplier, with one squaring per exponent bit and one
// more product per set bit. The divider and the multiplier loops set the run
// time. The result sits in an output register, so the next candidate may
// be accepted while it waits to be taken. Config writes are taken only while
// the block is idle, and a pending config write goes ahead of a candidate.
// ----------------------------------------------------------------------------
module primitive_root_test_top #(
  parameter int MAX_FACTORS  = 16,
  parameter int MODULUS_BITS = 31,
  parameter int TRIAL_LIMIT  = 65536
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // config channel: prime_modulus
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [MODULUS_BITS-1:0]                 cfg_data,
  // input stream, tdata: candidate, zero padded to bytes
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  input  logic [((MODULUS_BITS + 7) / 8) * 8-1:0] s_tdata,
  // output stream, tdata: is_primitive_root in bit 0, zero padded
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  output logic [7:0]                              m_tdata
);

  import prt_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_write;
  logic    in_accept;
  logic    out_free;
  logic    idle;
  logic    result;

  // register writes wait until the sequencer is idle
  assign cfg_ready = idle;
  assign cfg_write = cfg_valid && cfg_ready;

  // a pending register write goes first
  assign s_tready  = idle && !cfg_valid;
  assign in_accept = s_tvalid && s_tready;

  // the output register frees when empty or being taken this cycle
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {7'b0, result};

  prt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .in_accept (in_accept),
    .out_free  (out_free),
    .status    (status),
    .idle      (idle),
    .cmd       (cmd)
  );

  prt_datapath #(
    .W    (MODULUS_BITS),
    .MAXF (MAX_FACTORS),
    .TL   (TRIAL_LIMIT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_value (cfg_data),
    .candidate (s_tdata[MODULUS_BITS-1:0]),
    .cmd       (cmd),
    .status    (status)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result <= cmd.out_bit;
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the primitive root test block
// ----------------------------------------------------------------------------
// Candidate words are streamed in under several moduli, from the register
// extremes to small primes and composites. Each verdict is predicted by an
// independent model: trial-division factor cache plus square-and-multiply. The
// verdict words are checked in order against the queue of predicted verdicts.
// Both stream sides idle at random; one test holds the output off for a long
// stretch while the input keeps offering words.
// ----------------------------------------------------------------------------
module tb;

  localparam int  MODULUS_BITS = 31;
  localparam int  TRIAL_LIMIT  = 65536;
  localparam int  MAX_FACTORS  = 16;
  localparam int  CYCLE_LIMIT  = 12_000_000;
  localparam int  TAIL_CYCLES  = 60;
  localparam logic [30:0] MOD_MAX = 31'h7fff_ffff;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [30:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // bit 30..0 candidate, bit 31 zero pad
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // bit 0 is_primitive_root, bits 7..1 zero pad

  primitive_root_test_top #(
    .MAX_FACTORS (MAX_FACTORS),
    .MODULUS_BITS(MODULUS_BITS),
    .TRIAL_LIMIT (TRIAL_LIMIT)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // model state: modulus, cached factors of p-1 and whether they match p
  longint unsigned modulus;
  longint unsigned factor_list [MAX_FACTORS];
  int              factor_total;
  bit              factors_valid;

  logic [7:0] verdict_queue [$];   // predicted verdict words, oldest first
  int         error_count;
  int         cycle_count;
  int         hold_off;            // cycles the receiver still holds off
  bit         quiet;               // no random idling on either side while set

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** primitive_root_test_top: FAILED **");
      $finish;
    end
  end

  // idle lengths: mostly none or short, now and then long
  function automatic int gap_length();
    int r;
    begin
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
    end
  endfunction

  // ---- prediction ----------------------------------------------------------

  function automatic longint unsigned mod_power(longint unsigned base,
                                                longint unsigned expo,
                                                longint unsigned m);
    longint unsigned acc, sq, e;
    begin
      acc = 1 % m;
      sq  = base % m;
      e   = expo;
      while (e > 0) begin
        if (e[0]) acc = (acc * sq) % m;
        sq = (sq * sq) % m;
        e  = e >> 1;
      end
      return acc;
    end
  endfunction

  // distinct prime factors of p-1 by trial division, cofactor kept whole
  task automatic factorise_modulus();
    longint unsigned rest, d;
    begin
      rest = modulus - 1;
      factor_total = 0;
      for (d = 2; d < TRIAL_LIMIT && d * d <= rest; d++) begin
        if (rest % d == 0) begin
          if (factor_total < MAX_FACTORS) begin
            factor_list[factor_total] = d;
            factor_total++;
          end
          while (rest % d == 0) rest = rest / d;
        end
      end
      if (rest > 1 && factor_total < MAX_FACTORS) begin
        factor_list[factor_total] = rest;
        factor_total++;
      end
      factors_valid = 1'b1;
    end
  endtask

  task automatic predict_verdict(input logic [30:0] cand, output logic [7:0] word);
    longint unsigned g;
    bit yes;
    int i;
    begin
      word = 8'h00;
      if (modulus >= 2) begin
        if (!factors_valid) factorise_modulus();
        g = longint'(cand) % modulus;
        yes = (g != 0);
        for (i = 0; yes && i < factor_total; i++) begin
          if (factor_list[i] != 0 &&
              mod_power(g, (modulus - 1) / factor_list[i], modulus) == 1)
            yes = 1'b0;
        end
        word[0] = yes;
      end
    end
  endtask

  // ---- driving -------------------------------------------------------------

  // called at a falling edge, returns at a falling edge
  task automatic send_candidate(input logic [30:0] cand);
    int gap;
    logic [7:0] word;
    begin
      gap = gap_length();
      if (gap > 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_tvalid = 1'b1;
      s_tdata  = {1'b0, cand};
      forever begin
        @(posedge clk);
        if (s_tready) break;
      end
      predict_verdict(cand, word);
      verdict_queue.insert(verdict_queue.size(), word);
      @(negedge clk);
    end
  endtask

  // sender pause until every predicted verdict has been taken
  task automatic drain();
    begin
      s_tvalid = 1'b0;
      while (verdict_queue.size() != 0) @(negedge clk);
      repeat (TAIL_CYCLES) @(negedge clk);
    end
  endtask

  task automatic write_modulus(input logic [30:0] value);
    begin
      drain();
      cfg_valid = 1'b1;
      cfg_data  = value;
      forever begin
        @(posedge clk);
        if (cfg_ready) break;
      end
      modulus = value;
      factors_valid = 1'b0;
      @(negedge clk);
      cfg_valid = 1'b0;
    end
  endtask

  // receiver: random stalls, plus the long hold-off when asked
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        m_tready = 1'b0;
        hold_off--;
      end else if (!quiet && $urandom_range(0, 99) < 30) begin
        m_tready = 1'b0;
        repeat (gap_length()) begin
          @(negedge clk);
          if (hold_off > 0) hold_off--;
        end
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // verdict checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_queue.size() == 0) begin
        $display("%0t: verdict word %h with none expected", $time, m_tdata);
        error_count++;
      end else begin
        if (m_tdata[0] !== verdict_queue[0][0]) begin
          $display("%0t: is_primitive_root expected %b actual %b (p=%0d)",
                   $time, verdict_queue[0][0], m_tdata[0], modulus);
          error_count++;
        end
        if (m_tdata[7:1] !== verdict_queue[0][7:1]) begin
          $display("%0t: pad bits expected %h actual %h", $time,
                   verdict_queue[0][7:1], m_tdata[7:1]);
          error_count++;
        end
        void'(verdict_queue.pop_front());
      end
    end
  end

  // ---- tests ---------------------------------------------------------------

  // reset modulus two, then 7, the extremes 0 and MOD_MAX, 1, a composite and 65537
  task automatic test_directed();
    begin
      quiet = 1'b1;
      send_candidate(31'd0);
      send_candidate(31'd1);
      send_candidate(31'd2);
      send_candidate(31'd3);
      send_candidate(MOD_MAX);
      quiet = 1'b0;
      write_modulus(31'd7);
      send_candidate(31'd3);
      send_candidate(31'd2);
      send_candidate(31'd14);   // multiple of p
      send_candidate(31'd5);
      send_candidate(MOD_MAX);
      write_modulus(31'd0);     // no group at all
      send_candidate(31'd5);
      write_modulus(31'd1);
      send_candidate(31'd3);
      write_modulus(31'd15);    // not prime
      send_candidate(31'd2);
      send_candidate(31'd7);
      write_modulus(MOD_MAX);   // largest modulus, p-1 is smooth
      send_candidate(31'd7);
      send_candidate(31'd2);
      send_candidate(MOD_MAX);  // equals p
      send_candidate(31'h7fff_fffe);
      write_modulus(31'd65537);
      send_candidate(31'd3);
      send_candidate(31'd65536);
    end
  endtask

  // long receiver hold-off while the sender keeps offering words
  task automatic test_output_stall();
    int i;
    begin
      write_modulus(31'd257);
      quiet = 1'b1;
      hold_off = 3000;
      for (i = 0; i < 8; i++) send_candidate($urandom() & MOD_MAX);
      quiet = 1'b0;
      drain();
    end
  endtask

  // random phases, mostly small moduli so each word stays cheap
  task automatic test_random(input int words);
    int sent, n, i, pick;
    logic [30:0] p, cand;
    begin
      sent = 0;
      while (sent < words) begin
        pick = $urandom_range(0, 19);
        if (pick == 0)      p = MOD_MAX;
        else if (pick == 1) p = 31'd65537;
        else if (pick == 2) p = 31'd2;
        else                p = 31'($urandom_range(2, 300));
        write_modulus(p);
        n = (pick <= 1) ? $urandom_range(2, 5) : $urandom_range(20, 80);
        quiet = ($urandom_range(0, 5) == 0);
        for (i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0: cand = 31'($urandom_range(0, 400));
            1: cand = 31'(p * $urandom_range(0, 3));
            default: cand = $urandom() & MOD_MAX;
          endcase
          send_candidate(cand);
        end
        sent += n;
        quiet = 1'b0;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    error_count = 0;
    cycle_count = 0;
    hold_off = 0;
    quiet = 1'b0;
    modulus = 2;
    factor_total = 0;
    factors_valid = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_output_stall();
    test_random(1000);

    drain();
    if (error_count == 0) begin
      $display("** primitive_root_test_top: PASSED **");
    end else begin
      $display("** primitive_root_test_top: FAILED **");
    end
    $finish;
  end

endmodule
